>>> rtl/bsc_pkg.sv
package bsc_pkg;

    localparam int CAL_BYTES = 21;
    localparam int CAL_W     = 8 * CAL_BYTES;
    localparam int CFG_W     = 64;
    localparam int HIGH_W    = 40;

    // width of one slice of the wide operand in the sliced multiplier
    localparam int CHUNK_W = 24;

    localparam logic [1:0] REG_CAL_LOW  = 2'd0;
    localparam logic [1:0] REG_CAL_MID  = 2'd1;
    localparam logic [1:0] REG_CAL_HIGH = 2'd2;

    typedef logic [CAL_W-1:0] calib_t;

endpackage

>>> rtl/bsc_mul.sv
module bsc_mul #(
    parameter int WA = 34,
    parameter int WB = 24
) (
    input  logic                       clk,
    input  logic                       adv,
    input  logic signed [WA-1:0]       a,
    input  logic signed [WB-1:0]       b,
    output logic signed [WA+WB-1:0]    p
);

    localparam int CW  = bsc_pkg::CHUNK_W;
    localparam int NCH = (WA + CW - 1) / CW;
    localparam int AW  = NCH * CW;
    localparam int PW  = CW + 1 + WB;
    localparam int SW  = AW + WB;

    logic signed [AW-1:0]    a_ext;
    logic signed [PW-1:0]    part_next [NCH];
    logic signed [PW-1:0]    part_reg  [NCH];
    logic signed [SW-1:0]    sum_next;
    logic signed [WA+WB-1:0] p_reg;

    assign a_ext = AW'(a);

    always_comb
    begin
        logic signed [CW:0] chunk;
        for (int k = 0; k < NCH; k++)
        begin
            if (k == NCH - 1)
            begin
                chunk = $signed({a_ext[AW-1], a_ext[k*CW +: CW]});
            end
            else
            begin
                chunk = $signed({1'b0, a_ext[k*CW +: CW]});
            end
            part_next[k] = PW'(chunk) * PW'(b);
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < NCH; k++)
        begin
            sum_next = sum_next + (SW'(part_reg[k]) <<< (k * CW));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NCH; k++)
            begin
                part_reg[k] <= part_next[k];
            end
            p_reg <= $signed(sum_next[WA+WB-1:0]);
        end
    end

    assign p = p_reg;

endmodule

>>> rtl/baro_sensor_compensation.sv
// Barometric pressure and temperature compensation.
// Sample channel: sample_valid / sample_stall carry one pressure_adc and
// temperature_adc pair, both 24-bit unsigned readings.
// Result channel: result_valid / result_stall carry temperature_q16 (degC * 2^16),
// pressure_q6 (Pa * 64) and saturated, set when either value was clipped.
// Calibration: 21 bytes in three words through cfg_we / cfg_index / cfg_wdata;
// write only while no request is in flight.
// One request is taken per cycle while no result is held by result_stall.
// The depth is set by the Horner chain in temperature: three sliced multiplies
// that register partial products, then their sum, with an add between them.
// When the receiver stalls a waiting result, the whole pipeline holds and
// sample_stall rises; a bubble-free pipeline resumes at full rate.
// Reset clears the calibration words and all valid bits; no result is
// pending after reset.
module baro_sensor_compensation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_wdata,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic [23:0]        pressure_adc,
    input  logic [23:0]        temperature_adc,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [23:0] temperature_q16,
    output logic [23:0]        pressure_q6,
    output logic               saturated
);

    localparam int NST = 16;

    logic [63:0]               cal_low_reg;
    logic [63:0]               cal_mid_reg;
    logic [bsc_pkg::HIGH_W-1:0] cal_high_reg;
    bsc_pkg::calib_t           cal;

    logic [15:0]        t1;
    logic signed [16:0] t2s;
    logic signed [7:0]  t3s;
    logic signed [16:0] p1s;
    logic signed [16:0] p2s;
    logic signed [7:0]  p3s;
    logic signed [7:0]  p4s;
    logic signed [16:0] p5s;
    logic signed [16:0] p6s;
    logic signed [7:0]  p7s;
    logic signed [7:0]  p8s;
    logic signed [15:0] p9s;
    logic signed [7:0]  p10s;
    logic signed [7:0]  p11s;

    logic              adv;
    logic [NST:1]      vld_reg;

    logic [23:0]        up_s1_reg;
    logic [23:0]        ut_s1_reg;
    logic [23:0]        up_s2_reg;
    logic signed [25:0] d_next;
    logic signed [25:0] d_s2_reg;
    logic [23:0]        up_s3_reg;
    logic signed [42:0] dt2_next;
    logic signed [42:0] dt2_s3_reg;
    logic signed [51:0] dd_next;
    logic signed [51:0] dd_s3_reg;
    logic [47:0]        usq_next;
    logic [47:0]        usq_s3_reg;
    logic [23:0]        up_s4_reg;
    logic [47:0]        usq_s4_reg;
    logic signed [61:0] nt_next;
    logic signed [61:0] nt_s4_reg;
    logic [23:0]        up_s5_reg;
    logic [47:0]        usq_s5_reg;
    logic signed [61:0] tr;
    logic signed [23:0] tq_next;
    logic               satt_next;
    logic signed [23:0] tq_s5_reg;
    logic               satt_s5_reg;
    logic signed [73:0] ucb_s5;

    logic signed [24:0]  ups;
    logic signed [48:0]  usqs;
    logic signed [32:0]  up_p4;
    logic signed [32:0]  up_p3;
    logic signed [41:0]  up_p2;
    logic signed [56:0]  usq_p10;
    logic signed [41:0]  up_p1;
    logic signed [64:0]  usq_p9;
    logic signed [81:0]  ucb_p11;
    logic signed [33:0]  c3_next;
    logic signed [55:0]  c2_next;
    logic signed [83:0]  c1_next;
    logic signed [111:0] c0_next;
    logic signed [33:0]  c3_reg;
    logic signed [55:0]  c2_line_reg [3];
    logic signed [83:0]  c1_line_reg [6];
    logic signed [111:0] c0_line_reg [9];
    logic signed [23:0]  t_line_reg  [11];
    logic                sat_line_reg [10];

    logic signed [57:0]  h3;
    logic signed [58:0]  sum2_next;
    logic signed [58:0]  sum2_reg;
    logic signed [82:0]  h2;
    logic signed [84:0]  sum1_next;
    logic signed [84:0]  sum1_reg;
    logic signed [108:0] h1;
    logic signed [111:0] acc_next;
    logic signed [111:0] acc_reg;
    logic [23:0]         pq_next;
    logic                psat_next;
    logic [23:0]         pq_reg;
    logic                sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_low_reg  <= '0;
            cal_mid_reg  <= '0;
            cal_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bsc_pkg::REG_CAL_LOW:  cal_low_reg  <= cfg_wdata;
                bsc_pkg::REG_CAL_MID:  cal_mid_reg  <= cfg_wdata;
                bsc_pkg::REG_CAL_HIGH: cal_high_reg <= cfg_wdata[bsc_pkg::HIGH_W-1:0];
                default: ;
            endcase
        end
    end

    assign cal  = {cal_high_reg, cal_mid_reg, cal_low_reg};
    assign t1   = cal[15:0];
    assign t2s  = $signed({1'b0, cal[31:16]});
    assign t3s  = $signed(cal[39:32]);
    assign p1s  = 17'($signed(cal[55:40])) - 17'sd16384;
    assign p2s  = 17'($signed(cal[71:56])) - 17'sd16384;
    assign p3s  = $signed(cal[79:72]);
    assign p4s  = $signed(cal[87:80]);
    assign p5s  = $signed({1'b0, cal[103:88]});
    assign p6s  = $signed({1'b0, cal[119:104]});
    assign p7s  = $signed(cal[127:120]);
    assign p8s  = $signed(cal[135:128]);
    assign p9s  = $signed(cal[151:136]);
    assign p10s = $signed(cal[159:152]);
    assign p11s = $signed(cal[167:160]);

    assign adv          = !vld_reg[NST] || !result_stall;
    assign sample_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-1:1], sample_valid};
        end
    end

    // temperature
    assign d_next   = $signed({2'b00, ut_s1_reg}) - $signed({2'b00, t1, 8'h00});
    assign dt2_next = 43'(d_s2_reg) * 43'(t2s);
    assign dd_next  = 52'(d_s2_reg) * 52'(d_s2_reg);
    assign usq_next = 48'(up_s2_reg) * 48'(up_s2_reg);
    assign nt_next  = (62'(dt2_s3_reg) <<< 18) + 62'(dd_s3_reg) * 62'(t3s);
    assign tr       = (nt_s4_reg + 62'sd2147483648) >>> 32;

    always_comb
    begin
        satt_next = 1'b0;
        tq_next   = tr[23:0];
        if (tr > 62'sd8388607)
        begin
            tq_next   = 24'sh7FFFFF;
            satt_next = 1'b1;
        end
        else if (tr < -62'sd8388608)
        begin
            tq_next   = 24'sh800000;
            satt_next = 1'b1;
        end
    end

    bsc_mul #(.WA(49), .WB(25)) u_mul_cube (
        .clk (clk),
        .adv (adv),
        .a   ($signed({1'b0, usq_s3_reg})),
        .b   ($signed({1'b0, up_s3_reg})),
        .p   (ucb_s5)
    );

    // coefficients of t^0 .. t^3
    assign ups     = $signed({1'b0, up_s5_reg});
    assign usqs    = $signed({1'b0, usq_s5_reg});
    assign up_p4   = 33'(ups) * 33'(p4s);
    assign up_p3   = 33'(ups) * 33'(p3s);
    assign up_p2   = 42'(ups) * 42'(p2s);
    assign usq_p10 = 57'(usqs) * 57'(p10s);
    assign up_p1   = 42'(ups) * 42'(p1s);
    assign usq_p9  = 65'(usqs) * 65'(p9s);
    assign ucb_p11 = 82'(ucb_s5) * 82'(p11s);

    assign c3_next = (34'(p8s) <<< 22) + 34'(up_p4);
    assign c2_next = (56'(p7s) <<< 45) + (56'(up_p3) <<< 21);
    assign c1_next = (84'(p6s) <<< 63) + (84'(up_p2) <<< 40) + (84'(usq_p10) <<< 21);
    assign c0_next = (112'(p5s) <<< 88) + (112'(up_p1) <<< 65)
                   + (112'(usq_p9) <<< 37) + (112'(ucb_p11) <<< 20);

    bsc_mul #(.WA(34), .WB(24)) u_mul_h3 (
        .clk (clk),
        .adv (adv),
        .a   (c3_reg),
        .b   (t_line_reg[0]),
        .p   (h3)
    );

    assign sum2_next = 59'(c2_line_reg[2]) + 59'(h3);

    bsc_mul #(.WA(59), .WB(24)) u_mul_h2 (
        .clk (clk),
        .adv (adv),
        .a   (sum2_reg),
        .b   (t_line_reg[3]),
        .p   (h2)
    );

    assign sum1_next = 85'(c1_line_reg[5]) + 85'(h2);

    bsc_mul #(.WA(85), .WB(24)) u_mul_h1 (
        .clk (clk),
        .adv (adv),
        .a   (sum1_reg),
        .b   (t_line_reg[6]),
        .p   (h1)
    );

    // add half an output step for rounding
    assign acc_next = c0_line_reg[8] + 112'(h1) + (112'sd1 <<< 78);

    always_comb
    begin
        psat_next = 1'b0;
        pq_next   = acc_reg[102:79];
        if (acc_reg[111])
        begin
            pq_next   = '0;
            psat_next = 1'b1;
        end
        else if (acc_reg[110:103] != '0)
        begin
            pq_next   = 24'hFFFFFF;
            psat_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            up_s1_reg   <= pressure_adc;
            ut_s1_reg   <= temperature_adc;
            up_s2_reg   <= up_s1_reg;
            d_s2_reg    <= d_next;
            up_s3_reg   <= up_s2_reg;
            dt2_s3_reg  <= dt2_next;
            dd_s3_reg   <= dd_next;
            usq_s3_reg  <= usq_next;
            up_s4_reg   <= up_s3_reg;
            usq_s4_reg  <= usq_s3_reg;
            nt_s4_reg   <= nt_next;
            up_s5_reg   <= up_s4_reg;
            usq_s5_reg  <= usq_s4_reg;
            tq_s5_reg   <= tq_next;
            satt_s5_reg <= satt_next;
            c3_reg      <= c3_next;
            c2_line_reg[0] <= c2_next;
            for (int k = 1; k < 3; k++)
            begin
                c2_line_reg[k] <= c2_line_reg[k-1];
            end
            c1_line_reg[0] <= c1_next;
            for (int k = 1; k < 6; k++)
            begin
                c1_line_reg[k] <= c1_line_reg[k-1];
            end
            c0_line_reg[0] <= c0_next;
            for (int k = 1; k < 9; k++)
            begin
                c0_line_reg[k] <= c0_line_reg[k-1];
            end
            t_line_reg[0] <= tq_s5_reg;
            for (int k = 1; k < 11; k++)
            begin
                t_line_reg[k] <= t_line_reg[k-1];
            end
            sat_line_reg[0] <= satt_s5_reg;
            for (int k = 1; k < 10; k++)
            begin
                sat_line_reg[k] <= sat_line_reg[k-1];
            end
            sum2_reg <= sum2_next;
            sum1_reg <= sum1_next;
            acc_reg  <= acc_next;
            pq_reg   <= pq_next;
            sat_reg  <= psat_next || sat_line_reg[9];
        end
    end

    assign result_valid    = vld_reg[NST];
    assign temperature_q16 = t_line_reg[10];
    assign pressure_q6     = pq_reg;
    assign saturated       = sat_reg;

endmodule

>>> rtl/bsc_checker.sv
module bsc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               sample_valid,
    input logic               sample_stall,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [23:0] temperature_q16,
    input logic [23:0]        pressure_q6,
    input logic               saturated
);

    // hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(temperature_q16)
            && $stable(pressure_q6) && $stable(saturated))
        else $error("stalled result changed");

    a_free_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !sample_stall)
        else $error("sample stalled with no result waiting");

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> sample_stall)
        else $error("sample taken while result is held");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid && !sample_valid |=> !result_valid || !$past(sample_stall))
        else $error("pipeline advance broken");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (.*);
